>>> rtl/core/srtq_pkg.sv
// srtq_pkg: widths, reset values, register indexes and the divider stage type
// for the t/q scale-and-round block; no dependencies
`timescale 1ns / 1ps

package srtq_pkg;

  // coefficient bits taken from each input beat
  localparam int COEF_WIDTH = 62;

  // port and register widths
  localparam int COEF_IN_W = 62;
  localparam int OUT_W     = 62;
  localparam int Q_W       = 63;
  localparam int T_W       = 62;
  localparam int CFG_W     = 63;
  localparam int NUM_REGS  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODULUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PLAIN_MODULUS  = CFG_IDX_W'(1);

  localparam logic [Q_W-1:0] Q_RESET = Q_W'(65537);
  localparam logic [T_W-1:0] T_RESET = T_W'(256);

  // multiplier split into four half-width partial products
  localparam int MUL_W  = T_W;
  localparam int HALF   = (MUL_W + 1) / 2;
  localparam int HI_W   = MUL_W - HALF;
  localparam int PP_W   = 2 * HALF;
  localparam int FULL_W = 2 * PP_W;

  // exact product width, one divider cell per product bit
  localparam int PROD_W = COEF_WIDTH + T_W;
  localparam int REM_W  = Q_W;

  // output skid buffer
  localparam int SKID_DEPTH = 2;
  localparam int SKID_PTR_W = 1;
  localparam int SKID_CNT_W = 2;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] num;
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  res;
    logic              qbit;
  } srtq_div_t;

endpackage

>>> rtl/core/srtq_if.sv
// srtq_in_if / srtq_out_if: valid-ready stream channels for coefficients
// depends on srtq_pkg for payload widths
`timescale 1ns / 1ps

interface srtq_in_if;
  logic                           valid;
  logic                           ready;
  logic [srtq_pkg::COEF_IN_W-1:0] coef_in;

  modport source (output valid, output coef_in, input ready);
  modport sink (input valid, input coef_in, output ready);
endinterface

interface srtq_out_if;
  logic                       valid;
  logic                       ready;
  logic [srtq_pkg::OUT_W-1:0] coef_out;

  modport source (output valid, output coef_out, input ready);
  modport sink (input valid, input coef_out, output ready);
endinterface

>>> rtl/core/srtq_mul.sv
// srtq_mul: three-stage coefficient times t product from four half-width
// partial products; depends on srtq_pkg
`timescale 1ns / 1ps

module srtq_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          run,
  input  logic                          in_valid,
  input  logic [srtq_pkg::COEF_WIDTH-1:0] coef,
  input  logic [srtq_pkg::T_W-1:0]      t,
  output logic                          out_valid,
  output logic [srtq_pkg::PROD_W-1:0]   prod
);
  import srtq_pkg::*;

  logic [MUL_W-1:0]  c_ext;
  logic [HALF-1:0]   a0, b0;
  logic [HI_W-1:0]   a1, b1;
  logic [PP_W-1:0]   pp00_next, pp01_next, pp10_next, pp11_next;
  logic [PP_W-1:0]   pp00, pp01, pp10, pp11;
  logic [PP_W:0]     mid;
  logic [FULL_W-1:0] lohi;
  logic [FULL_W-1:0] full_next;
  logic              v1, v2;

  assign c_ext = MUL_W'(coef);
  assign a0 = c_ext[HALF-1:0];
  assign a1 = c_ext[MUL_W-1:HALF];
  assign b0 = t[HALF-1:0];
  assign b1 = t[MUL_W-1:HALF];

  assign pp00_next = a0 * b0;
  assign pp01_next = a0 * b1;
  assign pp10_next = a1 * b0;
  assign pp11_next = a1 * b1;

  // low and high partials do not overlap, so they simply concatenate
  assign full_next = lohi + (FULL_W'(mid) << HALF);

  always_ff @(posedge clk) begin
    if (run) begin
      pp00 <= pp00_next;
      pp01 <= pp01_next;
      pp10 <= pp10_next;
      pp11 <= pp11_next;
      mid  <= {1'b0, pp01} + {1'b0, pp10};
      lohi <= {pp11, pp00};
      prod <= full_next[PROD_W-1:0];
    end
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (run) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

>>> rtl/core/srtq_cell.sv
// srtq_cell: one restoring-division step on the product plus one step of
// the running quotient residue mod q; depends on srtq_pkg
`timescale 1ns / 1ps

module srtq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      run,
  input  logic [srtq_pkg::Q_W-1:0]  q,
  input  srtq_pkg::srtq_div_t       prev,
  output srtq_pkg::srtq_div_t       cur
);
  import srtq_pkg::*;

  logic [REM_W:0]   q_ext;
  logic [REM_W:0]   rem_sh, rem_dif;
  logic [REM_W:0]   res_sh, res_dif;
  logic             rem_ge, res_ge;
  logic [REM_W-1:0] rem_next, res_next;

  assign q_ext = {1'b0, q};

  // next product bit into the remainder, msb first
  assign rem_sh   = {prev.rem, prev.num[PROD_W-1]};
  assign rem_dif  = rem_sh - q_ext;
  assign rem_ge   = (rem_sh >= q_ext);
  assign rem_next = rem_ge ? rem_dif[REM_W-1:0] : rem_sh[REM_W-1:0];

  // quotient bit from the cell before folds into quotient mod q
  assign res_sh   = {prev.res, prev.qbit};
  assign res_dif  = res_sh - q_ext;
  assign res_ge   = (res_sh >= q_ext);
  assign res_next = res_ge ? res_dif[REM_W-1:0] : res_sh[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (run) begin
      cur.num  <= prev.num << 1;
      cur.rem  <= rem_next;
      cur.res  <= res_next;
      cur.qbit <= rem_ge;
    end
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (run) begin
      cur.valid <= prev.valid;
    end
  end

endmodule

>>> rtl/core/srtq_round.sv
// srtq_round: last residue step, half-up rounding and the two-entry output
// skid buffer that sets the pipeline advance; depends on srtq_pkg, srtq_if
`timescale 1ns / 1ps

module srtq_round (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [srtq_pkg::Q_W-1:0] q,
  input  srtq_pkg::srtq_div_t      last,
  output logic                     run,
  srtq_out_if.source               dout
);
  import srtq_pkg::*;

  logic [REM_W:0]      q_ext;
  logic [REM_W:0]      res_sh, res_dif;
  logic                res_ge;
  logic [REM_W-1:0]    res_a_next;
  logic                inc_a_next;
  logic                valid_a;
  logic [REM_W-1:0]    res_a;
  logic                inc_a;
  logic [REM_W-1:0]    res_inc;
  logic                wrap;
  logic [REM_W-1:0]    result;
  logic [OUT_W-1:0]    coef_val;
  logic                push, pop;
  logic [OUT_W-1:0]    slot [SKID_DEPTH];
  logic [SKID_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [SKID_CNT_W-1:0] cnt, cnt_next;

  assign q_ext = {1'b0, q};

  // stage a: fold in the last quotient bit, rounding bit from the remainder
  assign res_sh     = {last.res, last.qbit};
  assign res_dif    = res_sh - q_ext;
  assign res_ge     = (res_sh >= q_ext);
  assign res_a_next = res_ge ? res_dif[REM_W-1:0] : res_sh[REM_W-1:0];
  assign inc_a_next = ({last.rem, 1'b0} >= q_ext);

  always_ff @(posedge clk) begin
    if (run) begin
      res_a <= res_a_next;
      inc_a <= inc_a_next;
    end
    if (rst) begin
      valid_a <= 1'b0;
    end else if (run) begin
      valid_a <= last.valid;
    end
  end

  // stage b: residue is below q, so adding one wraps only at q - 1
  assign res_inc  = res_a + REM_W'(inc_a);
  assign wrap     = inc_a && (res_inc == q);
  assign result   = ((q == '0) || wrap) ? '0 : res_inc;
  assign coef_val = OUT_W'(result[COEF_WIDTH-1:0]);

  assign push = run && valid_a;
  assign pop  = dout.valid && dout.ready;

  assign run           = (cnt != SKID_CNT_W'(SKID_DEPTH));
  assign dout.valid    = (cnt != '0);
  assign dout.coef_out = slot[rd_ptr];

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 1'b1;
    end else if (pop && !push) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= coef_val;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= SKID_CNT_W'(SKID_DEPTH))
    else $error("skid count above depth");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!run && valid_a) |=> (valid_a && $stable(res_a) && $stable(inc_a)))
    else $error("stage a changed while the pipeline was stalled");

  a_fill_stalls: assert property (@(posedge clk) disable iff (rst)
    (cnt == SKID_CNT_W'(SKID_DEPTH - 1) && push && !pop) |=> !run)
    else $error("pipeline kept running with the skid buffer full");

endmodule

>>> rtl/core/scale_round_t_over_q_top.sv
// scale_round_t_over_q_top: coef_out = round_half_up(coef_in * t / q) mod q
// pipeline: 3 multiplier stages + one divider cell per product bit
//   (COEF_WIDTH + 62) + 2 rounding/output stages; one beat per cycle
// unless stalled by the full two-entry output skid that absorbs back-pressure
// synchronous active-high reset: q = 65537, t = 256, pipeline and skid empty
`timescale 1ns / 1ps

module scale_round_t_over_q_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [srtq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srtq_pkg::CFG_W-1:0]     cfg_data,
  srtq_in_if.sink                        din,
  srtq_out_if.source                     dout
);
  import srtq_pkg::*;

  logic [Q_W-1:0]    cipher_modulus;
  logic [T_W-1:0]    plain_modulus;
  logic              run;
  logic              mul_valid;
  logic [PROD_W-1:0] prod;
  srtq_div_t         div_chain [PROD_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_modulus <= Q_RESET;
      plain_modulus  <= T_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CIPHER_MODULUS: cipher_modulus <= cfg_data[Q_W-1:0];
        REG_PLAIN_MODULUS:  plain_modulus  <= cfg_data[T_W-1:0];
        default: ;
      endcase
    end
  end

  assign din.ready = run;

  srtq_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .run       (run),
    .in_valid  (din.valid),
    .coef      (din.coef_in[COEF_WIDTH-1:0]),
    .t         (plain_modulus),
    .out_valid (mul_valid),
    .prod      (prod)
  );

  assign div_chain[0].valid = mul_valid;
  assign div_chain[0].num   = prod;
  assign div_chain[0].rem   = '0;
  assign div_chain[0].res   = '0;
  assign div_chain[0].qbit  = 1'b0;

  // one cell per product bit, msb first
  for (genvar k = 0; k < PROD_W; k++) begin : g_cell
    srtq_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .run  (run),
      .q    (cipher_modulus),
      .prev (div_chain[k]),
      .cur  (div_chain[k+1])
    );
  end

  srtq_round u_round (
    .clk  (clk),
    .rst  (rst),
    .q    (cipher_modulus),
    .last (div_chain[PROD_W]),
    .run  (run),
    .dout (dout)
  );

endmodule

>>> test/tb_scale_round_t_over_q_top.sv
// tb_scale_round_t_over_q_top: stream test of round(coef*t/q) mod q against a wide-integer
// predictor, with directed moduli corners, random settings and back-pressure
// depends on srtq_pkg, srtq_in_if / srtq_out_if and scale_round_t_over_q_top
`timescale 1ns / 1ps

module tb_scale_round_t_over_q_top;
  import srtq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 200;
  localparam logic [COEF_IN_W-1:0] COEF_MASK = {COEF_IN_W{1'b1}} >> (COEF_IN_W - COEF_WIDTH);
  localparam logic [COEF_IN_W-1:0] COEF_MAX  = {COEF_IN_W{1'b1}};

  class coef_scoreboard;
    logic [Q_W-1:0]   q_reg;
    logic [T_W-1:0]   t_reg;
    logic [OUT_W-1:0] scaled_fifo[$];
    int               errors;

    function new();
      q_reg  = Q_RESET;
      t_reg  = T_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_CIPHER_MODULUS) q_reg = data[Q_W-1:0];
      else if (idx == REG_PLAIN_MODULUS) t_reg = data[T_W-1:0];
    endfunction

    function logic [OUT_W-1:0] scaled_coef(logic [COEF_IN_W-1:0] coef);
      logic [124:0] prod;
      logic [124:0] quo;
      logic [124:0] red;
      logic [Q_W-1:0] rem;
      logic [Q_W:0] twice_rem;
      if (q_reg == '0) return '0;
      prod = 125'(coef & COEF_MASK) * 125'(t_reg);
      quo = prod / 125'(q_reg);
      rem = Q_W'(prod % 125'(q_reg));
      twice_rem = {rem, 1'b0};
      // round half up
      if (twice_rem >= {1'b0, q_reg}) quo = quo + 125'd1;
      red = quo % 125'(q_reg);
      return OUT_W'(red) & COEF_MASK;
    endfunction

    function void note_coef(logic [COEF_IN_W-1:0] coef);
      scaled_fifo = {scaled_fifo, scaled_coef(coef)};
    endfunction

    function void check_coef(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] expected;
      if (scaled_fifo.size() == 0) begin
        $error("coef_out: unexpected beat, expected none, actual 0x%0h", actual);
        errors++;
        return;
      end
      expected = scaled_fifo.pop_front();
      if (actual !== expected) begin
        $error("coef_out: expected 0x%0h, actual 0x%0h", expected, actual);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  srtq_in_if  din_ch ();
  srtq_out_if dout_ch ();

  scale_round_t_over_q_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_ch),
    .dout      (dout_ch)
  );

  coef_scoreboard sb = new();
  int idle_level = 0;
  bit hold_req = 1'b0;
  int cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1)
      sb.check_coef(dout_ch.coef_out);
  end

  function automatic bit idle_now();
    case (idle_level)
      1: return $urandom_range(0, 7) == 0;
      2: return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    dout_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        dout_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_now()) begin
        dout_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (w >= 64) ? r : (r & ((64'd1 << w) - 64'd1));
  endfunction

  function automatic logic [COEF_IN_W-1:0] pick_coef(logic [Q_W-1:0] q);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return r[COEF_IN_W-1:0];
      2: return COEF_IN_W'(r[7:0]);
      default: return (q > 1) ? COEF_IN_W'(r % 64'(q)) : r[COEF_IN_W-1:0];
    endcase
  endfunction

  task automatic push_coef(input logic [COEF_IN_W-1:0] coef);
    if (idle_now()) begin
      din_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    din_ch.valid   <= 1'b1;
    din_ch.coef_in <= coef;
    do @(posedge clk); while (din_ch.ready !== 1'b1);
    sb.note_coef(coef);
  endtask

  task automatic drain();
    din_ch.valid <= 1'b0;
    while (sb.scaled_fifo.size() != 0) @(posedge clk);
  endtask

  // registers only change with the pipeline empty
  task automatic set_moduli(input logic [CFG_W-1:0] q_data, input logic [CFG_W-1:0] t_data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CIPHER_MODULUS;
    cfg_data  <= q_data;
    @(posedge clk);
    sb.set_reg(REG_CIPHER_MODULUS, q_data);
    cfg_index <= REG_PLAIN_MODULUS;
    cfg_data  <= t_data;
    @(posedge clk);
    sb.set_reg(REG_PLAIN_MODULUS, t_data);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_items);
    logic [CFG_W-1:0] q_data;
    logic [CFG_W-1:0] t_data;
    int w;
    case ($urandom_range(0, 19))
      0: q_data = '0;
      1: q_data = CFG_W'(1);
      2: q_data = {CFG_W{1'b1}};
      default: begin
        w = $urandom_range(2, Q_W);
        q_data = CFG_W'(rand_bits(w) | (64'd1 << (w - 1)));
      end
    endcase
    w = $urandom_range(1, T_W);
    t_data = ($urandom_range(0, 15) == 0) ? '0 : CFG_W'(rand_bits(w));
    // bit above t's width is ignored by the block
    t_data[CFG_W-1] = $urandom_range(0, 1);
    set_moduli(q_data, t_data);
    for (int i = 0; i < n_items; i++) push_coef(pick_coef(sb.q_reg));
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_CIPHER_MODULUS;
    cfg_data       <= '0;
    din_ch.valid   <= 1'b0;
    din_ch.coef_in <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset moduli q = 65537, t = 256
    idle_level = 1;
    push_coef('0);
    push_coef(COEF_IN_W'(1));
    push_coef(COEF_IN_W'(65536));
    push_coef(COEF_MAX);
    push_coef({31{2'b10}});
    push_coef({31{2'b01}});

    // exact halves round up; t written with its unused top bit set
    set_moduli(CFG_W'(4), {1'b1, T_W'(2)});
    push_coef(COEF_IN_W'(1));
    push_coef(COEF_IN_W'(3));
    push_coef(COEF_IN_W'(2));

    // zero modulus gives zero
    set_moduli('0, CFG_W'(5));
    push_coef(COEF_IN_W'(7));
    push_coef(COEF_MAX);

    // unit modulus
    set_moduli(CFG_W'(1), CFG_W'({T_W{1'b1}}));
    push_coef(COEF_MAX);
    push_coef(COEF_IN_W'(12345));

    // zero multiplier
    set_moduli(CFG_W'(1000003), '0);
    push_coef(COEF_MAX);
    push_coef(COEF_IN_W'(999));

    // widest q and t
    set_moduli({CFG_W{1'b1}}, CFG_W'({T_W{1'b1}}));
    push_coef(COEF_MAX);
    push_coef(COEF_MAX - 1);
    push_coef(COEF_IN_W'(1) << 61);

    set_moduli(CFG_W'(1) << 62, CFG_W'(3));
    push_coef(COEF_MAX);
    push_coef((COEF_IN_W'(1) << 61) + 1);

    // q above 2^62: reduced value can need 63 bits
    set_moduli((CFG_W'(1) << 62) + 1, CFG_W'({T_W{1'b1}}));
    push_coef(COEF_MAX);
    push_coef(COEF_MAX - 5);

    for (int p = 0; p < 6; p++) begin
      if (p == 1) begin
        // sender streams without gaps while the receiver holds off
        idle_level = 0;
        drain();
        @(posedge clk);
        hold_req = 1'b1;
        random_phase(250);
      end else begin
        idle_level = (p == 5) ? 0 : $urandom_range(0, 2);
        random_phase(100);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.scaled_fifo.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
